### sv/kbmk_pkg.sv
// Shared types, constants and the key decode table for the mouse keys block.
// Used by the front, queue, back and top level modules; no dependencies.
package kbmk_pkg;

   // Field and register widths
   localparam int PERIOD_W   = 20;
   localparam int STEP_W     = 7;
   localparam int TIMER_W    = 22;
   localparam int CODE_W     = 10;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;

   // Default depth of the job queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // Configuration register indexes and reset values
   localparam logic [CSR_IDX_W-1:0] CSR_MOVE_PERIOD  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WHEEL_PERIOD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MOVE_STEP    = 2'd2;

   localparam logic [PERIOD_W-1:0] MOVE_PERIOD_RST  = 20'd15000;
   localparam logic [PERIOD_W-1:0] WHEEL_PERIOD_RST = 20'd30000;
   localparam logic [STEP_W-1:0]   MOVE_STEP_RST    = 7'd4;

   // Input command and event codes
   localparam logic       CMD_KEY       = 1'b0;
   localparam logic       CMD_TICK      = 1'b1;
   localparam logic [4:0] EV_KEY        = 5'd1;
   localparam logic [1:0] KEY_VAL_PRESS = 2'd1;

   // Result kinds and codes
   localparam logic [1:0] KIND_KEY  = 2'd0;
   localparam logic [1:0] KIND_REL  = 2'd1;
   localparam logic [1:0] KIND_SYNC = 2'd2;
   localparam logic [1:0] KIND_QUIT = 2'd3;

   localparam logic [CODE_W-1:0] REL_X         = 10'd0;
   localparam logic [CODE_W-1:0] REL_Y         = 10'd1;
   localparam logic [CODE_W-1:0] REL_WHEEL     = 10'd8;
   localparam logic [CODE_W-1:0] BUTTON_LEFT   = 10'd272;
   localparam logic [CODE_W-1:0] BUTTON_RIGHT  = 10'd273;
   localparam logic [CODE_W-1:0] BUTTON_MIDDLE = 10'd274;

   // Speed exponents (factor is two to this power)
   localparam logic signed [2:0] SPEED_EXP_MIN     = -3'sd2;
   localparam logic signed [2:0] SPEED_EXP_HALF    = -3'sd1;
   localparam logic signed [2:0] SPEED_EXP_ONE     = 3'sd0;
   localparam logic signed [2:0] SPEED_EXP_DOUBLE  = 3'sd1;
   localparam logic signed [2:0] SPEED_EXP_MAX     = 3'sd2;

   // Held direction and wheel bit positions
   localparam logic [1:0] DIR_UP    = 2'd0;
   localparam logic [1:0] DIR_DOWN  = 2'd1;
   localparam logic [1:0] DIR_LEFT  = 2'd2;
   localparam logic [1:0] DIR_RIGHT = 2'd3;
   localparam logic       WHL_UP    = 1'b0;
   localparam logic       WHL_DOWN  = 1'b1;

   // Linux key codes used by the map
   localparam logic [CODE_W-1:0] KC_ESC        = 10'd1;
   localparam logic [CODE_W-1:0] KC_BACKSPACE  = 10'd14;
   localparam logic [CODE_W-1:0] KC_TAB        = 10'd15;
   localparam logic [CODE_W-1:0] KC_Q          = 10'd16;
   localparam logic [CODE_W-1:0] KC_E          = 10'd18;
   localparam logic [CODE_W-1:0] KC_R          = 10'd19;
   localparam logic [CODE_W-1:0] KC_P          = 10'd25;
   localparam logic [CODE_W-1:0] KC_ENTER      = 10'd28;
   localparam logic [CODE_W-1:0] KC_LEFTCTRL   = 10'd29;
   localparam logic [CODE_W-1:0] KC_A          = 10'd30;
   localparam logic [CODE_W-1:0] KC_S          = 10'd31;
   localparam logic [CODE_W-1:0] KC_D          = 10'd32;
   localparam logic [CODE_W-1:0] KC_F          = 10'd33;
   localparam logic [CODE_W-1:0] KC_H          = 10'd35;
   localparam logic [CODE_W-1:0] KC_J          = 10'd36;
   localparam logic [CODE_W-1:0] KC_K          = 10'd37;
   localparam logic [CODE_W-1:0] KC_L          = 10'd38;
   localparam logic [CODE_W-1:0] KC_LEFTSHIFT  = 10'd42;
   localparam logic [CODE_W-1:0] KC_N          = 10'd49;
   localparam logic [CODE_W-1:0] KC_RIGHTSHIFT = 10'd54;
   localparam logic [CODE_W-1:0] KC_KPASTERISK = 10'd55;
   localparam logic [CODE_W-1:0] KC_LEFTALT    = 10'd56;
   localparam logic [CODE_W-1:0] KC_SPACE      = 10'd57;
   localparam logic [CODE_W-1:0] KC_CAPSLOCK   = 10'd58;
   localparam logic [CODE_W-1:0] KC_KP7        = 10'd71;
   localparam logic [CODE_W-1:0] KC_KP8        = 10'd72;
   localparam logic [CODE_W-1:0] KC_KP9        = 10'd73;
   localparam logic [CODE_W-1:0] KC_KPMINUS    = 10'd74;
   localparam logic [CODE_W-1:0] KC_KP4        = 10'd75;
   localparam logic [CODE_W-1:0] KC_KP5        = 10'd76;
   localparam logic [CODE_W-1:0] KC_KP6        = 10'd77;
   localparam logic [CODE_W-1:0] KC_KPPLUS     = 10'd78;
   localparam logic [CODE_W-1:0] KC_KP2        = 10'd80;
   localparam logic [CODE_W-1:0] KC_KPENTER    = 10'd96;
   localparam logic [CODE_W-1:0] KC_RIGHTCTRL  = 10'd97;
   localparam logic [CODE_W-1:0] KC_KPSLASH    = 10'd98;
   localparam logic [CODE_W-1:0] KC_RIGHTALT   = 10'd100;
   localparam logic [CODE_W-1:0] KC_HOME       = 10'd102;
   localparam logic [CODE_W-1:0] KC_UP         = 10'd103;
   localparam logic [CODE_W-1:0] KC_PAGEUP     = 10'd104;
   localparam logic [CODE_W-1:0] KC_LEFT       = 10'd105;
   localparam logic [CODE_W-1:0] KC_RIGHT      = 10'd106;
   localparam logic [CODE_W-1:0] KC_END        = 10'd107;
   localparam logic [CODE_W-1:0] KC_DOWN       = 10'd108;
   localparam logic [CODE_W-1:0] KC_PAGEDOWN   = 10'd109;
   localparam logic [CODE_W-1:0] KC_MENU       = 10'd139;

   // Result slots in emission order; a job is a mask over these
   localparam int SLOT_N = 8;
   localparam logic [2:0] SLOT_QUIT       = 3'd0;
   localparam logic [2:0] SLOT_KEY        = 3'd1;
   localparam logic [2:0] SLOT_KEY_SYNC   = 3'd2;
   localparam logic [2:0] SLOT_MOVE_X     = 3'd3;
   localparam logic [2:0] SLOT_MOVE_Y     = 3'd4;
   localparam logic [2:0] SLOT_MOVE_SYNC  = 3'd5;
   localparam logic [2:0] SLOT_WHEEL      = 3'd6;
   localparam logic [2:0] SLOT_WHEEL_SYNC = 3'd7;

   // Channel payloads
   typedef struct packed {
      logic              cmd;
      logic [4:0]        event_type;
      logic [CODE_W-1:0] key_code;
      logic [1:0]        key_value;
   } req_type;

   typedef struct packed {
      logic [1:0]        out_kind;
      logic [CODE_W-1:0] out_code;
      logic signed [7:0] out_value;
      logic              out_last;
   } rsp_type;

   // Classified work handed from front to back
   typedef struct packed {
      logic              quit;
      logic              key;
      logic              motion;
      logic              wheel;
      logic [CODE_W-1:0] key_code;
      logic              key_value;
      logic signed [7:0] x;
      logic signed [7:0] y;
      logic signed [1:0] w;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } job_slot_type;

   // Key map actions
   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_QUIT,
      ACT_SPEED_SET,
      ACT_SPEED_UP,
      ACT_SPEED_DOWN,
      ACT_DIR,
      ACT_WHEEL,
      ACT_FWD
   } key_act_type;

   typedef struct packed {
      key_act_type       act;
      logic [CODE_W-1:0] arg;
   } key_decode_type;

   // Map a key code to its action; arg holds exponent, bit index or forwarded code
   function automatic key_decode_type decode_key(input logic [CODE_W-1:0] code);
      key_decode_type d;
      d.act = ACT_NONE;
      d.arg = '0;
      case (code)
         KC_Q: d.act = ACT_QUIT;
         KC_F: begin
            d.act = ACT_SPEED_SET;
            d.arg = {7'd0, SPEED_EXP_MIN};
         end
         KC_D: begin
            d.act = ACT_SPEED_SET;
            d.arg = {7'd0, SPEED_EXP_HALF};
         end
         KC_S: begin
            d.act = ACT_SPEED_SET;
            d.arg = {7'd0, SPEED_EXP_DOUBLE};
         end
         KC_A: begin
            d.act = ACT_SPEED_SET;
            d.arg = {7'd0, SPEED_EXP_MAX};
         end
         KC_KPSLASH:    d.act = ACT_SPEED_UP;
         KC_KPASTERISK: d.act = ACT_SPEED_DOWN;
         KC_UP, KC_K, KC_KP8: begin
            d.act = ACT_DIR;
            d.arg = {8'd0, DIR_UP};
         end
         KC_DOWN, KC_J, KC_KP2: begin
            d.act = ACT_DIR;
            d.arg = {8'd0, DIR_DOWN};
         end
         KC_LEFT, KC_H, KC_KP4: begin
            d.act = ACT_DIR;
            d.arg = {8'd0, DIR_LEFT};
         end
         KC_RIGHT, KC_L, KC_KP6: begin
            d.act = ACT_DIR;
            d.arg = {8'd0, DIR_RIGHT};
         end
         KC_SPACE, KC_ENTER, KC_KPENTER, KC_KP7: begin
            d.act = ACT_FWD;
            d.arg = BUTTON_LEFT;
         end
         KC_E, KC_KP5: begin
            d.act = ACT_FWD;
            d.arg = BUTTON_MIDDLE;
         end
         KC_R, KC_MENU, KC_KP9: begin
            d.act = ACT_FWD;
            d.arg = BUTTON_RIGHT;
         end
         KC_PAGEUP, KC_P, KC_KPMINUS: begin
            d.act = ACT_WHEEL;
            d.arg = {9'd0, WHL_UP};
         end
         KC_PAGEDOWN, KC_N, KC_KPPLUS: begin
            d.act = ACT_WHEEL;
            d.arg = {9'd0, WHL_DOWN};
         end
         KC_RIGHTCTRL, KC_LEFTCTRL, KC_RIGHTSHIFT, KC_LEFTSHIFT, KC_RIGHTALT,
         KC_LEFTALT, KC_TAB, KC_ESC, KC_BACKSPACE, KC_HOME, KC_END: begin
            d.act = ACT_FWD;
            d.arg = code;
         end
         KC_CAPSLOCK: begin
            d.act = ACT_FWD;
            d.arg = KC_LEFTCTRL;
         end
         default: d.act = ACT_NONE;
      endcase
      return d;
   endfunction

endpackage

### sv/kbmk_chan_if.sv
// Valid/ready channel carrying one payload item per handshake.
// The payload type is set by the instantiating code; no package dependency.
interface kbmk_chan_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### sv/keyboard_to_mouse_keys.sv
// Top level of the mouse keys block: front end, job queue and back end.
// Depends on kbmk_pkg, kbmk_chan_if, kbmk_front, kbmk_queue and kbmk_back.
//
// Usage:
//   req_if carries input items (tick or keyboard event) under valid/ready;
//   rsp_if carries result items (key/button, relative axis, sync, quit),
//   out_last marking the final result of an input. csr_we/csr_index/csr_wdata
//   write move_period (0), wheel_period (1) and move_step (2); write only while
//   the block is idle.
// Throughput: the front takes one item per cycle while the job queue has room.
//   The back emits one result per cycle from its output register while the
//   receiver does not stall; an item has 1 to 5 results, and an item without
//   results is taken by the front alone and never enters the queue.
// Path: the first result of an item passes the queue write, then the back
//   load, then the output register; a stall can hold it at any of these.
// Reset: registers return to their defaults, speed factor to one, held keys
//   and timers to zero, queue and output stage empty.
// Stall: a stalled receiver holds the output register; the back stops, the
//   queue fills and req_if.ready drops when it is full.
module keyboard_to_mouse_keys #(
   parameter int QueueDepth = kbmk_pkg::QUEUE_DEPTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   kbmk_chan_if.sink                            req_if,
   kbmk_chan_if.source                          rsp_if,
   input  logic                                 csr_we,
   input  logic [kbmk_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [kbmk_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import kbmk_pkg::*;

   job_slot_type push;
   job_slot_type head;
   logic         q_full;
   logic         pop;

   // Accept and classify items
   kbmk_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_full    (q_full),
      .push      (push)
   );

   // Decouple classification from emission
   kbmk_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .full  (q_full),
      .head  (head)
   );

   // Emit results
   kbmk_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .pop    (pop),
      .rsp_if (rsp_if)
   );

endmodule

### sv/kbmk_front.sv
// Front end: accepts items, holds configuration, key state and period timers,
// and classifies each item into a job for the queue. Depends on kbmk_pkg.
module kbmk_front (
   input  logic                                 clock,
   input  logic                                 reset,
   kbmk_chan_if.sink                            req_if,
   input  logic                                 csr_we,
   input  logic [kbmk_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [kbmk_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                 q_full,
   output kbmk_pkg::job_slot_type               push
);
   import kbmk_pkg::*;

   logic [PERIOD_W-1:0] move_period_ff, move_period_in;
   logic [PERIOD_W-1:0] wheel_period_ff, wheel_period_in;
   logic [STEP_W-1:0]   move_step_ff, move_step_in;
   logic signed [2:0]   speed_exp_ff, speed_exp_in;
   logic [3:0]          dir_ff, dir_in;
   logic [1:0]          wheel_ff, wheel_in;
   logic [TIMER_W-1:0]  move_timer_ff, move_timer_in;
   logic [TIMER_W-1:0]  wheel_timer_ff, wheel_timer_in;

   logic                accept;
   logic                key_ok;
   key_decode_type      dec;
   job_type             job;
   logic [TIMER_W-1:0]  move_scaled;
   logic [TIMER_W-1:0]  wheel_scaled;
   logic signed [7:0]   step8;

   // Scale a base period by the speed exponent; zero counts as one
   function automatic logic [TIMER_W-1:0] scale_period(
      input logic [PERIOD_W-1:0] base,
      input logic signed [2:0]   e
   );
      logic [TIMER_W-1:0] ext;
      logic [2:0]         neg;
      logic [TIMER_W-1:0] p;
      ext = {2'b00, base};
      neg = 3'(-e);
      if (e > 3'sd0) begin
         p = ext << e[1:0];
      end else if (e < 3'sd0) begin
         p = ext >> neg[1:0];
      end else begin
         p = ext;
      end
      if (p == '0) begin
         p = TIMER_W'(1);
      end
      return p;
   endfunction

   // Count up and wrap at the period, also when already past it
   function automatic logic [TIMER_W-1:0] advance(
      input logic [TIMER_W-1:0] t,
      input logic [TIMER_W-1:0] period
   );
      logic [TIMER_W:0] n;
      n = {1'b0, t} + (TIMER_W+1)'(1);
      return (n >= {1'b0, period}) ? '0 : n[TIMER_W-1:0];
   endfunction

   assign req_if.ready = !q_full;
   assign accept       = req_if.valid && req_if.ready;
   assign dec          = decode_key(req_if.payload.key_code);
   assign key_ok       = (req_if.payload.event_type == EV_KEY)
                         && (req_if.payload.key_value <= KEY_VAL_PRESS);
   assign move_scaled  = scale_period(move_period_ff, speed_exp_ff);
   assign wheel_scaled = scale_period(wheel_period_ff, speed_exp_ff);
   assign step8        = {1'b0, move_step_ff};

   // Take configuration writes; indexes beyond the list are dropped
   always_comb begin
      move_period_in  = move_period_ff;
      wheel_period_in = wheel_period_ff;
      move_step_in    = move_step_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_MOVE_PERIOD:  move_period_in  = csr_wdata;
            CSR_WHEEL_PERIOD: wheel_period_in = csr_wdata;
            CSR_MOVE_STEP:    move_step_in    = csr_wdata[STEP_W-1:0];
            default:          move_step_in    = move_step_ff;
         endcase
      end
   end

   // Classify the item and update key state and timers
   always_comb begin
      speed_exp_in   = speed_exp_ff;
      dir_in         = dir_ff;
      wheel_in       = wheel_ff;
      move_timer_in  = move_timer_ff;
      wheel_timer_in = wheel_timer_ff;
      job            = '0;

      // Motion and wheel amounts from the held keys
      if (dir_ff[DIR_RIGHT] && !dir_ff[DIR_LEFT]) begin
         job.x = step8;
      end else if (dir_ff[DIR_LEFT] && !dir_ff[DIR_RIGHT]) begin
         job.x = -step8;
      end
      if (dir_ff[DIR_DOWN] && !dir_ff[DIR_UP]) begin
         job.y = step8;
      end else if (dir_ff[DIR_UP] && !dir_ff[DIR_DOWN]) begin
         job.y = -step8;
      end
      if (wheel_ff[WHL_UP] && !wheel_ff[WHL_DOWN]) begin
         job.w = 2'sd1;
      end else if (wheel_ff[WHL_DOWN] && !wheel_ff[WHL_UP]) begin
         job.w = -2'sd1;
      end
      job.key_code  = dec.arg;
      job.key_value = req_if.payload.key_value[0];

      if (accept) begin
         if (req_if.payload.cmd == CMD_TICK) begin
            job.motion     = (move_timer_ff == '0) && ((job.x != 8'sd0) || (job.y != 8'sd0));
            job.wheel      = (wheel_timer_ff == '0) && (job.w != 2'sd0);
            move_timer_in  = advance(move_timer_ff, move_scaled);
            wheel_timer_in = advance(wheel_timer_ff, wheel_scaled);
         end else if (key_ok) begin
            case (dec.act)
               ACT_QUIT: job.quit = 1'b1;
               ACT_SPEED_SET: begin
                  speed_exp_in = req_if.payload.key_value[0] ? signed'(dec.arg[2:0])
                                                             : SPEED_EXP_ONE;
               end
               ACT_SPEED_UP: begin
                  if (req_if.payload.key_value[0] && (speed_exp_ff < SPEED_EXP_MAX)) begin
                     speed_exp_in = speed_exp_ff + 3'sd1;
                  end
               end
               ACT_SPEED_DOWN: begin
                  if (req_if.payload.key_value[0] && (speed_exp_ff > SPEED_EXP_MIN)) begin
                     speed_exp_in = speed_exp_ff - 3'sd1;
                  end
               end
               ACT_DIR:   dir_in[dec.arg[1:0]] = req_if.payload.key_value[0];
               ACT_WHEEL: wheel_in[dec.arg[0]] = req_if.payload.key_value[0];
               ACT_FWD:   job.key = 1'b1;
               default:   job.key = 1'b0;
            endcase
         end
      end

      push.job   = job;
      push.valid = job.quit || job.key || job.motion || job.wheel;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         move_period_ff  <= MOVE_PERIOD_RST;
         wheel_period_ff <= WHEEL_PERIOD_RST;
         move_step_ff    <= MOVE_STEP_RST;
         speed_exp_ff    <= SPEED_EXP_ONE;
         dir_ff          <= '0;
         wheel_ff        <= '0;
         move_timer_ff   <= '0;
         wheel_timer_ff  <= '0;
      end else begin
         move_period_ff  <= move_period_in;
         wheel_period_ff <= wheel_period_in;
         move_step_ff    <= move_step_in;
         speed_exp_ff    <= speed_exp_in;
         dir_ff          <= dir_in;
         wheel_ff        <= wheel_in;
         move_timer_ff   <= move_timer_in;
         wheel_timer_ff  <= wheel_timer_in;
      end
   end

   a_speed_range: assert property (@(posedge clock) disable iff (reset)
      (speed_exp_ff >= SPEED_EXP_MIN) && (speed_exp_ff <= SPEED_EXP_MAX))
      else $error("speed exponent out of range");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> !q_full)
      else $error("job pushed into a full queue");

   a_motion_on_boundary: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_if.payload.cmd == CMD_TICK) && (move_timer_ff != '0))
      |-> !push.job.motion)
      else $error("motion report off the period boundary");

endmodule

### sv/kbmk_queue.sv
// Short job queue between the front and back ends.
// Depends on kbmk_pkg for the job types.
module kbmk_queue #(
   parameter int Depth = kbmk_pkg::QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  kbmk_pkg::job_slot_type push,
   input  logic                   pop,
   output logic                   full,
   output kbmk_pkg::job_slot_type head
);
   import kbmk_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   job_type         mem [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push;
   logic            do_pop;

   assign full       = (count_ff == CntW'(Depth));
   assign head.valid = (count_ff != '0);
   assign head.job   = mem[rd_ptr_ff];
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && head.valid;

   // Advance pointers with wrap and track the fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CntW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push.job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> !full)
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid)
      else $error("pop from empty queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(Depth))
      else $error("queue fill level beyond depth");

endmodule

### sv/kbmk_back.sv
// Back end: takes queued jobs, emits their results one per cycle unless the
// receiver stalls; output is registered. Depends on kbmk_pkg, kbmk_chan_if.
module kbmk_back (
   input  logic                   clock,
   input  logic                   reset,
   input  kbmk_pkg::job_slot_type head,
   output logic                   pop,
   kbmk_chan_if.source            rsp_if
);
   import kbmk_pkg::*;

   logic [SLOT_N-1:0] pend_ff, pend_in;
   job_type           cur_ff, cur_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic [SLOT_N-1:0] rest;
   logic [SLOT_N-1:0] new_mask;
   logic [2:0]        idx;
   logic              emit_ok;
   logic              fire;
   logic              load;

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_data_ff;

   // Pick the lowest pending slot and what stays after it
   always_comb begin
      idx = SLOT_QUIT;
      for (int i = SLOT_N - 1; i >= 0; i--) begin
         if (pend_ff[i]) begin
            idx = 3'(i);
         end
      end
   end

   assign rest    = pend_ff & (pend_ff - SLOT_N'(1));
   assign emit_ok = !rsp_valid_ff || rsp_if.ready;
   assign fire    = (pend_ff != '0) && emit_ok;
   assign load    = head.valid && ((pend_ff == '0) || (fire && (rest == '0)));
   assign pop     = load;

   // Expand a job into its result slots
   always_comb begin
      new_mask                  = '0;
      new_mask[SLOT_QUIT]       = head.job.quit;
      new_mask[SLOT_KEY]        = head.job.key;
      new_mask[SLOT_KEY_SYNC]   = head.job.key;
      new_mask[SLOT_MOVE_X]     = head.job.motion;
      new_mask[SLOT_MOVE_Y]     = head.job.motion;
      new_mask[SLOT_MOVE_SYNC]  = head.job.motion;
      new_mask[SLOT_WHEEL]      = head.job.wheel;
      new_mask[SLOT_WHEEL_SYNC] = head.job.wheel;
   end

   // Advance through the pending slots and load the next job
   always_comb begin
      pend_in = pend_ff;
      cur_in  = cur_ff;
      if (load) begin
         pend_in = new_mask;
         cur_in  = head.job;
      end else if (fire) begin
         pend_in = rest;
      end
   end

   // Fill the output register; hold it while the receiver stalls
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (fire) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.out_last  = (rest == '0);
         rsp_data_in.out_code  = '0;
         rsp_data_in.out_value = 8'sd0;
         case (idx)
            SLOT_QUIT: rsp_data_in.out_kind = KIND_QUIT;
            SLOT_KEY: begin
               rsp_data_in.out_kind  = KIND_KEY;
               rsp_data_in.out_code  = cur_ff.key_code;
               rsp_data_in.out_value = {7'd0, cur_ff.key_value};
            end
            SLOT_MOVE_X: begin
               rsp_data_in.out_kind  = KIND_REL;
               rsp_data_in.out_code  = REL_X;
               rsp_data_in.out_value = cur_ff.x;
            end
            SLOT_MOVE_Y: begin
               rsp_data_in.out_kind  = KIND_REL;
               rsp_data_in.out_code  = REL_Y;
               rsp_data_in.out_value = cur_ff.y;
            end
            SLOT_WHEEL: begin
               rsp_data_in.out_kind  = KIND_REL;
               rsp_data_in.out_code  = REL_WHEEL;
               rsp_data_in.out_value = {{6{cur_ff.w[1]}}, cur_ff.w};
            end
            default: rsp_data_in.out_kind = KIND_SYNC;
         endcase
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid)
      else $error("job taken from empty queue");

   a_more_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.out_last) |-> (pend_ff != '0))
      else $error("non-last result with nothing pending");

   a_quit_alone: assert property (@(posedge clock) disable iff (reset)
      pend_ff[SLOT_QUIT] |-> (pend_ff == (SLOT_N'(1) << SLOT_QUIT)))
      else $error("quit job carries other results");

   a_load_when_done: assert property (@(posedge clock) disable iff (reset)
      load |-> ((pend_ff == '0) || $onehot(pend_ff)))
      else $error("job loaded over pending results");

endmodule

### tb/kbmk_checker.sv
// Scoreboard for the mouse keys block: tracks config writes and accepted key/tick items,
// predicts the mouse events each one causes and compares them with the result channel.
// Depends on kbmk_pkg only.
module kbmk_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  kbmk_pkg::req_type               req_item,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  kbmk_pkg::rsp_type               rsp_item,
   input  logic                            csr_we,
   input  logic [kbmk_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [kbmk_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int unsigned                     mismatches,
   output int unsigned                     waiting
);
   timeunit 1ns;
   timeprecision 1ps;
   import kbmk_pkg::*;

   localparam int unsigned REPORT_MAX = 10;

   // Shadow copy of the block's registers and key state
   logic [PERIOD_W-1:0] move_period;
   logic [PERIOD_W-1:0] wheel_period;
   logic [STEP_W-1:0]   move_step;
   int                  speed_exp;
   logic [3:0]          dir_held;
   logic [1:0]          wheel_held;
   int unsigned         move_timer;
   int unsigned         wheel_timer;
   rsp_type             mouse_events [$];

   function automatic void push_event(input logic [1:0] kind, input logic [CODE_W-1:0] code,
                                      input logic signed [7:0] value);
      rsp_type ev;
      ev.out_kind  = kind;
      ev.out_code  = code;
      ev.out_value = value;
      ev.out_last  = 1'b0;
      mouse_events.push_back(ev);
   endfunction

   // Forward a key or button state, then a sync report
   function automatic void forward_key(input logic [CODE_W-1:0] code, input logic pressed);
      push_event(KIND_KEY, code, {7'd0, pressed});
      push_event(KIND_SYNC, '0, '0);
   endfunction

   // Scale the base period by the speed factor, never below one tick
   function automatic int unsigned scaled_period(input logic [PERIOD_W-1:0] base);
      int unsigned p;
      p = 32'(base);
      if (speed_exp > 0)
         p = p << speed_exp;
      else if (speed_exp < 0)
         p = p >> (-speed_exp);
      return (p == 0) ? 1 : p;
   endfunction

   function automatic int unsigned advance_timer(input int unsigned t,
                                                 input logic [PERIOD_W-1:0] base);
      return (t + 1 >= scaled_period(base)) ? 0 : t + 1;
   endfunction

   task automatic predict_mouse_events(input req_type it);
      int          x;
      int          y;
      int          w;
      int unsigned first;
      logic        pressed;
      first = mouse_events.size();
      if (it.cmd == CMD_TICK) begin
         x = int'(move_step) * (int'(dir_held[DIR_RIGHT]) - int'(dir_held[DIR_LEFT]));
         y = int'(move_step) * (int'(dir_held[DIR_DOWN]) - int'(dir_held[DIR_UP]));
         w = int'(wheel_held[WHL_UP]) - int'(wheel_held[WHL_DOWN]);
         // report at period boundaries only, motion ahead of wheel
         if (move_timer == 0 && (x != 0 || y != 0)) begin
            push_event(KIND_REL, REL_X, x[7:0]);
            push_event(KIND_REL, REL_Y, y[7:0]);
            push_event(KIND_SYNC, '0, '0);
         end
         if (wheel_timer == 0 && w != 0) begin
            push_event(KIND_REL, REL_WHEEL, w[7:0]);
            push_event(KIND_SYNC, '0, '0);
         end
         move_timer  = advance_timer(move_timer, move_period);
         wheel_timer = advance_timer(wheel_timer, wheel_period);
      end else if (it.event_type == EV_KEY && it.key_value <= KEY_VAL_PRESS) begin
         pressed = (it.key_value == KEY_VAL_PRESS);
         case (it.key_code)
            KC_Q: push_event(KIND_QUIT, '0, '0);
            KC_F: speed_exp = pressed ? int'(SPEED_EXP_MIN) : int'(SPEED_EXP_ONE);
            KC_D: speed_exp = pressed ? int'(SPEED_EXP_HALF) : int'(SPEED_EXP_ONE);
            KC_S: speed_exp = pressed ? int'(SPEED_EXP_DOUBLE) : int'(SPEED_EXP_ONE);
            KC_A: speed_exp = pressed ? int'(SPEED_EXP_MAX) : int'(SPEED_EXP_ONE);
            KC_KPSLASH: if (pressed && speed_exp < int'(SPEED_EXP_MAX)) speed_exp++;
            KC_KPASTERISK: if (pressed && speed_exp > int'(SPEED_EXP_MIN)) speed_exp--;
            KC_UP, KC_K, KC_KP8:       dir_held[DIR_UP]    = pressed;
            KC_DOWN, KC_J, KC_KP2:     dir_held[DIR_DOWN]  = pressed;
            KC_LEFT, KC_H, KC_KP4:     dir_held[DIR_LEFT]  = pressed;
            KC_RIGHT, KC_L, KC_KP6:    dir_held[DIR_RIGHT] = pressed;
            KC_PAGEUP, KC_P, KC_KPMINUS:  wheel_held[WHL_UP]   = pressed;
            KC_PAGEDOWN, KC_N, KC_KPPLUS: wheel_held[WHL_DOWN] = pressed;
            KC_SPACE, KC_ENTER, KC_KPENTER, KC_KP7: forward_key(BUTTON_LEFT, pressed);
            KC_E, KC_KP5:                           forward_key(BUTTON_MIDDLE, pressed);
            KC_R, KC_MENU, KC_KP9:                  forward_key(BUTTON_RIGHT, pressed);
            KC_CAPSLOCK:                            forward_key(KC_LEFTCTRL, pressed);
            KC_RIGHTCTRL, KC_LEFTCTRL, KC_RIGHTSHIFT, KC_LEFTSHIFT, KC_RIGHTALT,
            KC_LEFTALT, KC_TAB, KC_ESC, KC_BACKSPACE, KC_HOME, KC_END:
               forward_key(it.key_code, pressed);
            default: ;
         endcase
      end
      // flag the final event of this item
      if (mouse_events.size() > first)
         mouse_events[mouse_events.size() - 1].out_last = 1'b1;
   endtask

   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (mouse_events.size() == 0) begin
         mismatches++;
         if (mismatches <= REPORT_MAX)
            $display("%0t: result with nothing pending: kind %0d code %0d value %0d last %0d",
                     $time, got.out_kind, got.out_code, got.out_value, got.out_last);
      end else begin
         want = mouse_events.pop_front();
         if (got.out_kind !== want.out_kind || got.out_code !== want.out_code ||
             got.out_value !== want.out_value || got.out_last !== want.out_last) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display({"%0t: result mismatch: expected kind %0d code %0d value %0d last %0d,",
                         " got kind %0d code %0d value %0d last %0d"},
                        $time, want.out_kind, want.out_code, want.out_value, want.out_last,
                        got.out_kind, got.out_code, got.out_value, got.out_last);
         end
      end
   endtask

   // Check results first so a new item never feeds the comparison of an older one
   always @(posedge clock) begin
      if (reset) begin
         move_period  = MOVE_PERIOD_RST;
         wheel_period = WHEEL_PERIOD_RST;
         move_step    = MOVE_STEP_RST;
         speed_exp    = int'(SPEED_EXP_ONE);
         dir_held     = '0;
         wheel_held   = '0;
         move_timer   = 0;
         wheel_timer  = 0;
         mismatches   = 0;
         mouse_events.delete();
      end else begin
         if (rsp_valid && rsp_ready)
            check_result(rsp_item);
         if (csr_we) begin
            case (csr_index)
               CSR_MOVE_PERIOD:  move_period  = csr_wdata[PERIOD_W-1:0];
               CSR_WHEEL_PERIOD: wheel_period = csr_wdata[PERIOD_W-1:0];
               CSR_MOVE_STEP:    move_step    = csr_wdata[STEP_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            predict_mouse_events(req_item);
      end
      waiting = mouse_events.size();
   end

endmodule

### tb/keyboard_to_mouse_keys_tb.sv
// Top of the mouse keys testbench: clock, reset, key/tick stimulus, result-side stalls
// and the verdict. Depends on kbmk_pkg, kbmk_chan_if, keyboard_to_mouse_keys, kbmk_checker.
module keyboard_to_mouse_keys_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import kbmk_pkg::*;

   localparam int unsigned CYCLE_LIMIT     = 1_000_000;
   localparam int          PHASE_N         = 6;
   localparam int          PHASE_ITEMS     = 65;
   localparam int          PRESSURE_PHASE  = 4;
   localparam int          HOLD_OFF_CYCLES = 200;
   localparam int          SETTLE_CYCLES   = 10;

   localparam logic [1:0]        KEY_VAL_RELEASE = 2'd0;
   localparam logic [1:0]        KEY_VAL_REPEAT  = 2'd2;
   localparam logic [4:0]        EV_REL_TYPE     = 5'd2;
   localparam logic [CODE_W-1:0] KC_UNMAPPED     = 10'd1023;

   logic                  clock        = 1'b0;
   logic                  reset        = 1'b1;
   logic                  csr_we       = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index    = '0;
   logic [CSR_DATA_W-1:0] csr_wdata    = '0;
   logic                  hold_off_req = 1'b0;
   int unsigned           mismatches;
   int unsigned           waiting;
   int unsigned           cycles       = 0;

   // Every key code the block maps to an action
   logic [CODE_W-1:0] mapped_keys [46] = '{
      KC_Q, KC_F, KC_D, KC_S, KC_A, KC_KPSLASH, KC_KPASTERISK,
      KC_UP, KC_K, KC_KP8, KC_DOWN, KC_J, KC_KP2,
      KC_LEFT, KC_H, KC_KP4, KC_RIGHT, KC_L, KC_KP6,
      KC_SPACE, KC_ENTER, KC_KPENTER, KC_KP7, KC_E, KC_KP5,
      KC_R, KC_MENU, KC_KP9, KC_PAGEUP, KC_P, KC_KPMINUS,
      KC_PAGEDOWN, KC_N, KC_KPPLUS,
      KC_RIGHTCTRL, KC_LEFTCTRL, KC_RIGHTSHIFT, KC_LEFTSHIFT, KC_RIGHTALT,
      KC_LEFTALT, KC_TAB, KC_ESC, KC_BACKSPACE, KC_HOME, KC_END, KC_CAPSLOCK
   };

   // Register settings per random phase: move period, wheel period, step
   logic [CSR_DATA_W-1:0] phase_move  [PHASE_N] = '{20'd3, 20'd1048575, 20'd7, 20'd2,
                                                    20'd1, 20'd4};
   logic [CSR_DATA_W-1:0] phase_wheel [PHASE_N] = '{20'd5, 20'd1048575, 20'd2, 20'd13,
                                                    20'd1, 20'd9};
   logic [CSR_DATA_W-1:0] phase_step  [PHASE_N] = '{20'd1, 20'd64, 20'd127, 20'd0,
                                                    20'd5, 20'd33};

   kbmk_chan_if #(.payload_type(req_type)) req_ch ();
   kbmk_chan_if #(.payload_type(rsp_type)) rsp_ch ();

   keyboard_to_mouse_keys dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   kbmk_checker event_check (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_ready  (req_ch.ready),
      .req_item   (req_ch.payload),
      .rsp_valid  (rsp_ch.valid),
      .rsp_ready  (rsp_ch.ready),
      .rsp_item   (rsp_ch.payload),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .mismatches (mismatches),
      .waiting    (waiting)
   );

   always #1 clock = ~clock;

   // Abort a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Mostly back to back, sometimes a few cycles, rarely a long pause
   function automatic int pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      else if (r < 92)
         return $urandom_range(1, 4);
      return $urandom_range(10, 40);
   endfunction

   function automatic req_type key_item(input logic [CODE_W-1:0] code,
                                        input logic [1:0] value);
      req_type it;
      it.cmd        = CMD_KEY;
      it.event_type = EV_KEY;
      it.key_code   = code;
      it.key_value  = value;
      return it;
   endfunction

   // Tick fields other than cmd are don't-care; randomize them anyway
   function automatic req_type tick_item();
      req_type it;
      it.cmd        = CMD_TICK;
      it.event_type = 5'($urandom_range(0, 31));
      it.key_code   = 10'($urandom_range(0, 1023));
      it.key_value  = 2'($urandom_range(0, 3));
      return it;
   endfunction

   // Mix ticks, mapped key presses/releases and raw noise events
   function automatic req_type random_item();
      req_type     it;
      int unsigned r;
      r = $urandom_range(0, 99);
      it.cmd        = CMD_KEY;
      it.event_type = 5'($urandom_range(0, 31));
      it.key_code   = 10'($urandom_range(0, 1023));
      it.key_value  = 2'($urandom_range(0, 3));
      if (r < 40) begin
         it = tick_item();
      end else if (r < 86) begin
         it.event_type = EV_KEY;
         it.key_code   = mapped_keys[$urandom_range(0, 45)];
         it.key_value  = 2'($urandom_range(0, 1));
      end
      return it;
   endfunction

   // Offer one item and hold it until accepted; valid stays up when no gap follows
   task automatic send_item(input req_type it);
      int gap;
      @(negedge clock);
      req_ch.valid   = 1'b1;
      req_ch.payload = it;
      do @(posedge clock); while (!req_ch.ready);
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_ch.valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // Drop valid, drain every pending result, then let the block settle
   task automatic wait_idle();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (waiting != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic configure(input logic [CSR_DATA_W-1:0] move_period,
                            input logic [CSR_DATA_W-1:0] wheel_period,
                            input logic [CSR_DATA_W-1:0] move_step);
      wait_idle();
      write_csr(CSR_MOVE_PERIOD, move_period);
      write_csr(CSR_WHEEL_PERIOD, wheel_period);
      write_csr(CSR_MOVE_STEP, move_step);
   endtask

   // Result side: flow bursts (some long), random stalls, one long hold-off on request
   initial begin : receiver
      int   flow_left;
      int   stall_left;
      int   hold_left;
      logic hold_taken;
      flow_left     = 0;
      stall_left    = 0;
      hold_left     = 0;
      hold_taken    = 1'b0;
      rsp_ch.ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_ch.ready = 1'b0;
            hold_left--;
         end else if (flow_left > 0) begin
            rsp_ch.ready = 1'b1;
            flow_left--;
         end else if (stall_left > 0) begin
            rsp_ch.ready = 1'b0;
            stall_left--;
         end else begin
            flow_left    = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 7)
                                                      : $urandom_range(30, 120);
            stall_left   = pick_gap();
            rsp_ch.ready = 1'b1;
         end
      end
   end

   initial begin : stimulus
      req_type it;
      int      counted;
      req_ch.valid   = 1'b0;
      req_ch.payload = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset settings: idle tick, quit on press and on release
      send_item(tick_item());
      send_item(key_item(KC_Q, KEY_VAL_PRESS));
      send_item(key_item(KC_Q, KEY_VAL_RELEASE));

      // Shortest periods, largest step
      configure(20'd1, 20'd1, 20'd127);
      it = key_item(KC_SPACE, KEY_VAL_PRESS);
      it.event_type = EV_REL_TYPE;
      send_item(it);
      send_item(key_item(KC_SPACE, KEY_VAL_REPEAT));
      send_item(key_item(KC_UNMAPPED, KEY_VAL_PRESS));
      send_item(key_item(KC_SPACE, KEY_VAL_PRESS));
      send_item(key_item(KC_SPACE, KEY_VAL_RELEASE));
      send_item(key_item(KC_CAPSLOCK, KEY_VAL_PRESS));
      // full positive motion plus wheel up
      send_item(key_item(KC_RIGHT, KEY_VAL_PRESS));
      send_item(key_item(KC_DOWN, KEY_VAL_PRESS));
      send_item(key_item(KC_PAGEUP, KEY_VAL_PRESS));
      repeat (2) send_item(tick_item());
      // full negative motion plus wheel down
      send_item(key_item(KC_RIGHT, KEY_VAL_RELEASE));
      send_item(key_item(KC_DOWN, KEY_VAL_RELEASE));
      send_item(key_item(KC_LEFT, KEY_VAL_PRESS));
      send_item(key_item(KC_UP, KEY_VAL_PRESS));
      send_item(key_item(KC_PAGEUP, KEY_VAL_RELEASE));
      send_item(key_item(KC_PAGEDOWN, KEY_VAL_PRESS));
      send_item(tick_item());
      // speed steps saturate at both ends, then a set key release restores factor one
      repeat (3) send_item(key_item(KC_KPSLASH, KEY_VAL_PRESS));
      send_item(key_item(KC_F, KEY_VAL_PRESS));
      send_item(key_item(KC_KPASTERISK, KEY_VAL_PRESS));
      send_item(key_item(KC_A, KEY_VAL_RELEASE));

      // Random phases; only ticks and key presses/releases count toward the phase length
      for (int p = 0; p < PHASE_N; p++) begin
         configure(phase_move[p], phase_wheel[p], phase_step[p]);
         if (p == PRESSURE_PHASE)
            hold_off_req = 1'b1;
         counted = 0;
         while (counted < PHASE_ITEMS) begin
            it = random_item();
            send_item(it);
            if (it.cmd == CMD_TICK || (it.event_type == EV_KEY && it.key_value <= KEY_VAL_PRESS))
               counted++;
         end
      end

      wait_idle();
      if (mismatches == 0 && waiting == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
